// ----- design/llp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Least-loaded unit placement: shared package
// Sizes, command codes, controller states and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package llp_pkg;

    // Table sizes.
    localparam int NUM_UNITS  = 64;
    localparam int COUNT_BITS = 16;
    localparam int LOAD_BITS  = 16;
    localparam int IDX_W      = 6;
    localparam int UNIT_BITS  = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int KEY_BITS   = (COUNT_BITS > LOAD_BITS) ? COUNT_BITS : LOAD_BITS;

    // Command codes carried by the input word.
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_PLACE   = 2'd1,
        CMD_ASSIGN  = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_SCAN_END,
        ST_PICK,
        ST_READ,
        ST_MODIFY,
        ST_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic scan_issue;
        logic rd_count;
        logic wr_count;
        logic wr_load;
        logic take_pick;
        logic out_load;
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic any;
        logic out_free;
    } t_dp_stat;

endpackage : llp_pkg
`default_nettype wire

// ----- design/llp_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Least-loaded unit placement: controller
// Sequences one word at a time through load, scan, read-modify-write and
// result steps, driving the datapath by command strobes.
// ----------------------------------------------------------------------------
module llp_ctrl
    import llp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic [1:0] i_command,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_ctrl      o_ctrl
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command strobes.
    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.latch_in = 1'b1;
                    unique case (t_cmd'(i_command))
                        CMD_LOAD:    n_state = ST_LOAD;
                        CMD_PLACE:   n_state = ST_SCAN;
                        CMD_ASSIGN:  n_state = ST_READ;
                        CMD_RELEASE: n_state = ST_READ;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                o_ctrl.wr_load = 1'b1;
                n_state        = ST_RESULT;
            end
            ST_SCAN: begin
                o_ctrl.scan_issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            // The last candidate is compared during this cycle.
            ST_SCAN_END: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                o_ctrl.take_pick = 1'b1;
                n_state          = i_stat.any ? ST_READ : ST_RESULT;
            end
            ST_READ: begin
                o_ctrl.rd_count = 1'b1;
                n_state         = ST_MODIFY;
            end
            ST_MODIFY: begin
                o_ctrl.wr_count = 1'b1;
                n_state         = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule : llp_ctrl
`default_nettype wire

// ----- design/llp_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Least-loaded unit placement: datapath
// Count and load tables with per-entry valid bits, the candidate scan with
// its running minimum, the saturating count update and the output register.
// ----------------------------------------------------------------------------
module llp_dp
    import llp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_ctrl             i_ctrl,
    output t_dp_stat                  o_stat,
    input  wire logic [1:0]           i_command,
    input  wire logic [IDX_W-1:0]     i_unit_index,
    input  wire logic [LOAD_BITS-1:0] i_load_value,
    input  wire logic [63:0]          i_candidate_mask,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [IDX_W-1:0]          o_chosen_unit,
    output logic                      o_found
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Tables and their valid bits.
    logic [COUNT_BITS-1:0] m_count [NUM_UNITS];
    logic [LOAD_BITS-1:0]  m_load  [NUM_UNITS];
    logic [NUM_UNITS-1:0]  r_count_vld;
    logic [NUM_UNITS-1:0]  r_load_vld;
    logic                  r_loads_known;

    // Latched input word.
    t_cmd                  r_cmd;
    logic                  r_unit_ok;
    logic [LOAD_BITS-1:0]  r_load;
    logic [NUM_UNITS-1:0]  r_mask;
    logic [UNIT_BITS-1:0]  r_tgt;

    // Registered read data.
    logic [COUNT_BITS-1:0] r_count_q;
    logic [LOAD_BITS-1:0]  r_load_q;
    logic                  r_count_qv;
    logic                  r_load_qv;

    // Scan pipeline and running minimum.
    logic [UNIT_BITS-1:0]  r_scan_idx;
    logic                  r_pv;
    logic [UNIT_BITS-1:0]  r_pidx;
    logic                  r_pm;
    logic                  r_any;
    logic [UNIT_BITS-1:0]  r_best;
    logic [KEY_BITS-1:0]   r_best_key;
    logic                  r_any_used;
    logic [UNIT_BITS-1:0]  r_best_used;
    logic [KEY_BITS-1:0]   r_best_used_key;

    // Output register.
    logic                  r_out_valid;
    logic [IDX_W-1:0]      r_chosen;
    logic                  r_found;

    logic [UNIT_BITS-1:0]  rd_addr;
    logic [COUNT_BITS-1:0] cnt_eff;
    logic [LOAD_BITS-1:0]  load_eff;
    logic [KEY_BITS-1:0]   key;
    logic                  cand;
    logic                  take_best;
    logic                  take_used;
    logic [COUNT_BITS-1:0] n_count;
    logic                  count_we;
    logic                  load_we;
    logic                  in_ok;

    assign in_ok    = {1'b0, i_unit_index} < (IDX_W + 1)'(NUM_UNITS);
    assign rd_addr  = i_ctrl.scan_issue ? r_scan_idx : r_tgt;
    assign cnt_eff  = r_count_qv ? r_count_q : '0;
    assign load_eff = r_load_qv ? r_load_q : '0;
    assign count_we = i_ctrl.wr_count && ((r_cmd == CMD_PLACE) || r_unit_ok);
    assign load_we  = i_ctrl.wr_load && r_unit_ok;

    // Compare the candidate whose table entries were read last cycle.
    always_comb begin
        key       = r_loads_known ? KEY_BITS'(load_eff) : KEY_BITS'(cnt_eff);
        cand      = r_pv && r_pm;
        take_best = cand && (!r_any || (key < r_best_key));
        take_used = cand && r_loads_known && (cnt_eff != '0) &&
                    (!r_any_used || (key < r_best_used_key));
    end

    // Saturating count update.
    always_comb begin
        if (r_cmd == CMD_RELEASE) begin
            n_count = (cnt_eff == '0) ? cnt_eff : cnt_eff - 1'b1;
        end else begin
            n_count = (cnt_eff == CNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
        end
    end

    // Table storage: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan_issue || i_ctrl.rd_count) begin
            r_count_q  <= m_count[rd_addr];
            r_load_q   <= m_load[rd_addr];
            r_count_qv <= r_count_vld[rd_addr];
            r_load_qv  <= r_load_vld[rd_addr];
        end
        if (count_we) begin
            m_count[r_tgt] <= n_count;
        end
        if (load_we) begin
            m_load[r_tgt] <= r_load;
        end
    end

    // Valid bits and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_vld   <= '0;
            r_load_vld    <= '0;
            r_loads_known <= 1'b0;
            r_pv          <= 1'b0;
            r_any         <= 1'b0;
            r_any_used    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (count_we) begin
                r_count_vld[r_tgt] <= 1'b1;
            end
            if (load_we) begin
                r_load_vld[r_tgt] <= 1'b1;
                r_loads_known     <= 1'b1;
            end
            r_pv <= i_ctrl.scan_issue;
            if (i_ctrl.latch_in) begin
                r_any      <= 1'b0;
                r_any_used <= 1'b0;
            end else begin
                if (take_best) begin
                    r_any <= 1'b1;
                end
                if (take_used) begin
                    r_any_used <= 1'b1;
                end
            end
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch_in) begin
            r_cmd      <= t_cmd'(i_command);
            r_unit_ok  <= in_ok;
            r_load     <= i_load_value;
            r_mask     <= i_candidate_mask[NUM_UNITS-1:0];
            r_tgt      <= i_unit_index[UNIT_BITS-1:0];
            r_scan_idx <= '0;
        end else begin
            if (i_ctrl.scan_issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (i_ctrl.take_pick) begin
                r_tgt <= r_any_used ? r_best_used : r_best;
            end
        end
        if (i_ctrl.scan_issue) begin
            r_pidx <= r_scan_idx;
            r_pm   <= r_mask[r_scan_idx];
        end
        if (take_best) begin
            r_best     <= r_pidx;
            r_best_key <= key;
        end
        if (take_used) begin
            r_best_used     <= r_pidx;
            r_best_used_key <= key;
        end
        if (i_ctrl.out_load) begin
            r_found  <= (r_cmd == CMD_PLACE) && r_any;
            r_chosen <= ((r_cmd == CMD_PLACE) && r_any) ? IDX_W'(r_tgt) : '0;
        end
    end

    assign o_stat.scan_last = (r_scan_idx == UNIT_BITS'(NUM_UNITS - 1));
    assign o_stat.any       = r_any;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_chosen_unit = r_chosen;
    assign o_found       = r_found;

endmodule : llp_dp
`default_nettype wire

// ----- design/least_loaded_pu_placement.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Least-loaded processing-unit placement
// Keeps per-unit application counts and load samples and picks a unit for
// each place request.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one command word:
//   load sample, place, assign or release. Every word yields exactly one
//   result word on the output channel (o_out_valid / i_out_ready) carrying
//   o_chosen_unit and o_found; both are zero for all but a successful place.
//   One word is processed at a time. From acceptance to the registered
//   result: load sample writes the load table; assign and release read
//   then write the count table; place scans all NUM_UNITS entries, picks
//   a unit, then reads and writes its count, skipping that read and write
//   when no candidate is found. The place time is set by the candidate
//   scan, reading one table entry per cycle through the single read port.
//   The next word is accepted in the cycle after the result is loaded,
//   even while that result still waits at the output register.
//   If the receiver stalls with a result pending, the following word runs
//   to completion and then holds until the output register frees.
//   Synchronous reset clears all counts and loads to zero at once through
//   per-entry valid bits; the block accepts words straight after reset.
// ----------------------------------------------------------------------------
module least_loaded_pu_placement
    import llp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_command,
    input  wire logic [IDX_W-1:0]     i_unit_index,
    input  wire logic [LOAD_BITS-1:0] i_load_value,
    input  wire logic [63:0]          i_candidate_mask,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [IDX_W-1:0]          o_chosen_unit,
    output logic                      o_found
);

    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;

    // Sequencer.
    llp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_ctrl     (dp_ctrl)
    );

    // Tables, scan and output register.
    llp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (dp_ctrl),
        .o_stat           (dp_stat),
        .i_command        (i_command),
        .i_unit_index     (i_unit_index),
        .i_load_value     (i_load_value),
        .i_candidate_mask (i_candidate_mask),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_chosen_unit    (o_chosen_unit),
        .o_found          (o_found)
    );

endmodule : least_loaded_pu_placement
`default_nettype wire

// ----- design/llp_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Least-loaded unit placement: port checker
// Watches the top-level ports for result, handshake and reset behaviour.
// ----------------------------------------------------------------------------
module llp_checker
    import llp_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire logic [1:0]           i_command,
    input wire logic [IDX_W-1:0]     i_unit_index,
    input wire logic [LOAD_BITS-1:0] i_load_value,
    input wire logic [63:0]          i_candidate_mask,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [IDX_W-1:0]     o_chosen_unit,
    input wire logic                 o_found
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_chosen_unit) && $stable(o_found))
        else $error("result word changed while stalled");

    // A word without a found unit reports unit zero.
    a_zero_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_chosen_unit == '0)
        else $error("unit not zero when nothing found");

    // Only one word is in work at a time.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word accepted while one is in work");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word present after reset");

endmodule : llp_checker

bind least_loaded_pu_placement llp_checker u_llp_checker (.*);
`default_nettype wire

// ----- tb/sv/tb_least_loaded_pu_placement.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-loaded unit placement: self-checking testbench
// Offers command words through a bursty sender and takes result words
// through a stalling receiver. Every accepted word is run through a
// behavioural placement predictor. Each result word is then checked
// against the oldest prediction. The stimulus has five parts:
//   - a short directed opening;
//   - a run of assigns that stacks applications on one unit;
//   - directed least-loaded picks once load samples are known;
//   - random words without load samples, still ranked by load;
//   - random words with load samples, which exercise the least-loaded pick.
// ----------------------------------------------------------------------------
module tb_least_loaded_pu_placement;
    import llp_pkg::*;

    localparam int FILL_WORDS   = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = NUM_UNITS + 16;
    localparam int COUNT_ONLY_N = 300;
    localparam int LOADED_N     = 900;

    // One command word as offered to the block.
    typedef struct packed {
        t_cmd                 cmd;
        logic [IDX_W-1:0]     unit;
        logic [LOAD_BITS-1:0] load;
        logic [63:0]          mask;
        logic                 drain;
    } t_word;

    // One result word.
    typedef struct packed {
        logic [IDX_W-1:0] unit;
        logic             found;
    } t_pick;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [1:0]           command   = '0;
    logic [IDX_W-1:0]     unit_idx  = '0;
    logic [LOAD_BITS-1:0] load_val  = '0;
    logic [63:0]          cand_mask = '0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic [IDX_W-1:0]     chosen;
    logic                 found;

    // Predictor state: counts, load samples and the loads-known flag.
    logic [COUNT_BITS-1:0] app_cnt [NUM_UNITS];
    logic [LOAD_BITS-1:0]  unit_ld [NUM_UNITS];
    logic                  ld_known;

    t_word pend_words [$];
    t_pick exp_picks  [$];
    t_word cur;

    bit taken = 1'b0;
    int words_in = 0;
    int results_in = 0;
    int places_found = 0;
    int places_empty = 0;
    int err_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int pat_mode = 0;
    int pat_left = 0;
    int calm_lo = 32'h7fff_ffff;
    int calm_hi = 32'h7fff_ffff;
    int hold_at = 32'h7fff_ffff;

    least_loaded_pu_placement u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_command        (command),
        .i_unit_index     (unit_idx),
        .i_load_value     (load_val),
        .i_candidate_mask (cand_mask),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_chosen_unit    (chosen),
        .o_found          (found)
    );

    // Clock and a single reset at the start.
    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    function automatic void count_up(input int u);
        if (app_cnt[u] != '1) begin
            app_cnt[u] = app_cnt[u] + 1'b1;
        end
    endfunction

    // Applies one word to the predictor state and returns its result word.
    function automatic t_pick predict_placement(input t_word w);
        t_pick               r;
        logic                any;
        logic                any_used;
        logic [IDX_W-1:0]    best;
        logic [IDX_W-1:0]    best_used;
        logic [KEY_BITS-1:0] key;
        logic [KEY_BITS-1:0] best_key;
        logic [KEY_BITS-1:0] best_used_key;
        int                  i;
        r = '0;
        any = 1'b0;
        any_used = 1'b0;
        best = '0;
        best_used = '0;
        best_key = '0;
        best_used_key = '0;
        case (w.cmd)
            CMD_LOAD: begin
                if (int'(w.unit) < NUM_UNITS) begin
                    unit_ld[w.unit] = w.load;
                    ld_known = 1'b1;
                end
            end
            CMD_PLACE: begin
                for (i = 0; i < NUM_UNITS; i++) begin
                    if (w.mask[i]) begin
                        key = ld_known ? KEY_BITS'(unit_ld[i]) : KEY_BITS'(app_cnt[i]);
                        if (!any || key < best_key) begin
                            any = 1'b1;
                            best = IDX_W'(i);
                            best_key = key;
                        end
                        // Units already holding applications are preferred once loads are known.
                        if (ld_known && app_cnt[i] != '0 &&
                            (!any_used || key < best_used_key)) begin
                            any_used = 1'b1;
                            best_used = IDX_W'(i);
                            best_used_key = key;
                        end
                    end
                end
                if (any) begin
                    r.unit = any_used ? best_used : best;
                    r.found = 1'b1;
                    count_up(int'(r.unit));
                    places_found++;
                end else begin
                    places_empty++;
                end
            end
            CMD_ASSIGN: begin
                if (int'(w.unit) < NUM_UNITS) begin
                    count_up(int'(w.unit));
                end
            end
            CMD_RELEASE: begin
                if (int'(w.unit) < NUM_UNITS && app_cnt[w.unit] != '0) begin
                    app_cnt[w.unit] = app_cnt[w.unit] - 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void add_word(input t_cmd c, input int u, input int l,
                                     input logic [63:0] m, input bit d);
        t_word w;
        w.cmd = c;
        w.unit = IDX_W'(u);
        w.load = LOAD_BITS'(l);
        w.mask = m;
        w.drain = d;
        pend_words.push_back(w);
    endfunction

    // Random word. Units and loads lean towards small sets so that ties and
    // shared units are common.
    function automatic void add_random_word(input bit with_loads, input bit d);
        int          sel;
        int          u;
        int          l;
        int          k;
        logic [63:0] m;
        t_cmd        c;
        sel = $urandom_range(0, 9);
        if (with_loads && sel < 2) c = CMD_LOAD;
        else if (sel < 6) c = CMD_PLACE;
        else if (sel < 8) c = CMD_ASSIGN;
        else c = CMD_RELEASE;
        case ($urandom_range(0, 3))
            0, 1: u = $urandom_range(0, 63);
            2: u = $urandom_range(0, 7);
            default: u = $urandom_range(56, 63);
        endcase
        case ($urandom_range(0, 3))
            0: l = $urandom_range(0, 3);
            1: l = $urandom_range(0, 65535);
            2: l = ($urandom_range(0, 1) == 0) ? 0 : 65535;
            default: l = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 9))
            0: m = '1;
            1: m = {$urandom, $urandom};
            2: m = 64'd1 << $urandom_range(0, 63);
            3: m = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'hFF << (8 * $urandom_range(0, 7));
            4: m = {$urandom, $urandom} & {$urandom, $urandom};
            5: m = 64'hFFFF_FFFF_FFFF_FFFF << $urandom_range(0, 63);
            6: m = ~(64'd1 << $urandom_range(0, 63));
            default: begin
                m = '0;
                for (k = $urandom_range(1, 4); k > 0; k--) begin
                    m[$urandom_range(0, 63)] = 1'b1;
                end
            end
        endcase
        add_word(c, u, l, m, d);
    endfunction

    // Builds the whole stimulus list before the first word goes out.
    initial begin : stimulus
        int k;
        for (k = 0; k < NUM_UNITS; k++) begin
            app_cnt[k] = '0;
            unit_ld[k] = '0;
        end
        ld_known = 1'b0;

        // Fewest-applications picks, ties, an empty mask and the top unit.
        add_word(CMD_PLACE, 0, 0, '1, 1'b0);
        add_word(CMD_PLACE, 0, 0, '1, 1'b0);
        add_word(CMD_PLACE, 0, 0, 64'd0, 1'b0);
        add_word(CMD_PLACE, 0, 0, 64'h8000_0000_0000_0000, 1'b0);
        add_word(CMD_ASSIGN, 63, 0, '0, 1'b0);
        add_word(CMD_RELEASE, 5, 0, '0, 1'b0);
        add_word(CMD_RELEASE, 63, 0, '0, 1'b0);
        add_word(CMD_PLACE, 0, 0, 64'h8000_0000_0000_0002, 1'b0);
        add_word(CMD_PLACE, 0, 0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        add_word(CMD_ASSIGN, 2, 0, '0, 1'b0);
        add_word(CMD_PLACE, 0, 0, 64'h5, 1'b0);

        // Stack applications on unit 7 back to back, step back once, then
        // compare it with an empty unit and pick it on its own.
        calm_lo = pend_words.size();
        calm_hi = calm_lo + FILL_WORDS;
        for (k = 0; k < FILL_WORDS; k++) begin
            add_word(CMD_ASSIGN, 7, 0, '0, k == 0);
        end
        add_word(CMD_RELEASE, 7, 0, '0, 1'b0);
        add_word(CMD_PLACE, 0, 0, 64'h180, 1'b0);
        add_word(CMD_PLACE, 0, 0, 64'h80, 1'b0);

        // Least-loaded picks: unsampled units at zero, used units first.
        add_word(CMD_LOAD, 10, 16'hFFFF, '0, 1'b0);
        add_word(CMD_PLACE, 0, 0, '1, 1'b0);
        add_word(CMD_LOAD, 0, 16'hFFFF, '0, 1'b0);
        add_word(CMD_LOAD, 1, 16'h8000, '0, 1'b0);
        add_word(CMD_PLACE, 0, 0, 64'h403, 1'b0);
        add_word(CMD_PLACE, 0, 0, 64'h10_0400, 1'b0);
        add_word(CMD_LOAD, 63, 0, '0, 1'b0);
        add_word(CMD_PLACE, 0, 0, 64'h8000_0000_0000_0400, 1'b0);
        add_word(CMD_LOAD, 20, 16'hFFFF, '0, 1'b0);
        add_word(CMD_PLACE, 0, 0, 64'h10_0400, 1'b0);

        // Random words, first without load samples, then with them.
        for (k = 0; k < COUNT_ONLY_N; k++) begin
            add_random_word(1'b0, k == 0);
        end
        hold_at = pend_words.size() + 60;
        for (k = 0; k < LOADED_N; k++) begin
            add_random_word(1'b1, k == 0);
        end
    end

    // Acceptance of a command word: predict its result at the handshake.
    always @(posedge clk) begin
        taken = rst_n && in_valid && in_ready;
        if (taken) begin
            exp_picks.push_back(predict_placement(cur));
            words_in++;
        end
    end

    // Sender: bursts of words with random gaps, no gaps during the fill run.
    // A word marked for draining waits until every result has come back.
    always @(negedge clk) begin : driver
        logic launch;
        logic calm_now;
        launch = 1'b0;
        calm_now = (words_in >= calm_lo) && (words_in < calm_hi);
        if (taken) begin
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        if (calm_now) gap_left = 0;
        if (rst_n && (!in_valid || taken) && pend_words.size() != 0) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (!pend_words[0].drain || exp_picks.size() == 0) begin
                cur = pend_words.pop_front();
                launch = 1'b1;
            end
        end
        if (launch) begin
            in_valid  <= 1'b1;
            command   <= cur.cmd;
            unit_idx  <= cur.unit;
            load_val  <= cur.load;
            cand_mask <= cur.mask;
        end else if (!in_valid || taken) begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: random stall patterns, always ready during the fill run,
    // and one long hold-off that backs the block up to its input.
    always @(negedge clk) begin : receiver
        logic rdy;
        if (!hold_done && words_in >= hold_at) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (words_in >= calm_lo && words_in < calm_hi) begin
            rdy = 1'b1;
        end else begin
            if (pat_left == 0) begin
                pat_mode = $urandom_range(0, 3);
                pat_left = $urandom_range(8, 80);
            end
            pat_left--;
            case (pat_mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = ($urandom_range(0, 4) == 0);
                default: rdy = ($urandom_range(0, 3) != 0);
            endcase
        end
        out_ready <= rdy;
    end

    // Result check against the oldest outstanding prediction.
    always @(posedge clk) begin : monitor
        t_pick want;
        if (rst_n && out_valid && out_ready) begin
            results_in++;
            if (exp_picks.size() == 0) begin
                report_mismatch($sformatf("result word %0d with nothing outstanding",
                                          results_in));
            end else begin
                want = exp_picks.pop_front();
                if (chosen !== want.unit) begin
                    report_mismatch($sformatf("result word %0d: chosen unit %0d, expected %0d",
                                              results_in, chosen, want.unit));
                end
                if (found !== want.found) begin
                    report_mismatch($sformatf("result word %0d: found %0b, expected %0b",
                                              results_in, found, want.found));
                end
            end
        end
    end

    // End of run once everything has been sent and answered.
    initial begin : finish_run
        wait (rst_n === 1'b1);
        while (pend_words.size() != 0 || in_valid) @(posedge clk);
        while (exp_picks.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d command words, including a back-to-back run of %0d assigns.",
                 words_in, FILL_WORDS);
        $display("Checked %0d results: %0d picks found a unit, %0d had no candidate, %0d mismatches.",
                 results_in, places_found, places_empty, err_count);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin : watchdog
        #(25_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
